// ===== rtl/ipc_pkg.sv =====
// Shared types, register indexes and constants for the irrigation pump controller.
package ipc_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned MOIST_W    = 10;
    localparam int unsigned LED_W      = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned S_TDATA_W  = 48;
    localparam int unsigned M_TDATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_MOISTURE_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOISTURE_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP_MS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN_MS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_RUN_MS = 3'd4;

    localparam logic [MOIST_W-1:0] MOISTURE_LOW_RST  = 10'd300;
    localparam logic [MOIST_W-1:0] MOISTURE_HIGH_RST = 10'd600;
    localparam logic [TIME_W-1:0]  MIN_GAP_MS_RST    = 32'd600000;
    localparam logic [TIME_W-1:0]  MAX_RUN_MS_RST    = 32'd30000;
    localparam logic [TIME_W-1:0]  MANUAL_RUN_MS_RST = 32'd10000;

    localparam logic [LED_W-1:0] LED_IDLE    = 2'd0;
    localparam logic [LED_W-1:0] LED_PUMPING = 2'd1;
    localparam logic [LED_W-1:0] LED_ALERT   = 2'd2;

    typedef struct packed {
        logic [MOIST_W-1:0] moisture_low;
        logic [MOIST_W-1:0] moisture_high;
        logic [TIME_W-1:0]  min_gap_ms;
        logic [TIME_W-1:0]  max_run_ms;
        logic [TIME_W-1:0]  manual_run_ms;
    } cfg_t;

    typedef struct packed {
        logic               pump_press;
        logic               mode_press;
        logic [MOIST_W-1:0] moisture;
        logic [TIME_W-1:0]  now_ms;
    } item_t;

    typedef struct packed {
        logic [LED_W-1:0] led_state;
        logic             pump_on;
        logic             manual_mode;
    } result_t;

endpackage

// ===== rtl/irrigation_pump_controller_top.sv =====
// Top level: stream input register, controller core, result register, config port.
//
//  channel  | dir | handshake             | payload
//  s_       | in  | s_tvalid / s_tready   | s_tdata 48b: now_ms, moisture, mode_press, pump_press
//  m_       | out | m_tvalid / m_tready   | m_tdata 8b: manual_mode, pump_on, led_state
//  cfg_     | in  | cfg_valid / cfg_ready | cfg_index 3b, cfg_data 32b
//
// One transaction per cycle sustained while m_tready is high; s_ data passes the input
// register, the single update pass and the result register on its way to m_.
// Synchronous active-low reset clears valids, controller state and config to defaults.
// A stalled m_ side holds the result; the input register still takes one more
// transaction, then s_tready drops until the result is taken. cfg_ready is always high.
module irrigation_pump_controller_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [31:0] now_ms, [41:32] moisture, [42] mode_press, [43] pump_press, [47:44] unused
    input  logic [ipc_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] manual_mode, [1] pump_on, [3:2] led_state, [7:4] zero
    output logic [ipc_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ipc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ipc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    ipc_pkg::cfg_t     cfg;
    ipc_pkg::item_t    item_reg;
    ipc_pkg::result_t  result;
    ipc_pkg::result_t  out_reg;
    logic              in_valid_reg, in_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic              advance;
    logic              fire;

    assign cfg_ready = 1'b1;

    ipc_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_tdata[$bits(ipc_pkg::item_t)-1:0];
        end
        if (fire) begin
            out_reg <= result;
        end
    end

    ipc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (item_reg),
        .fire    (fire),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ipc_pkg::M_TDATA_W - $bits(ipc_pkg::result_t)){1'b0}}, out_reg};

endmodule

// ===== rtl/ipc_cfg_regs.sv =====
// Configuration register file with write decoder.
module ipc_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                wr_en,
    input  logic [ipc_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [ipc_pkg::CFG_DATA_W-1:0]      wr_data,
    output ipc_pkg::cfg_t                       cfg
);

    ipc_pkg::cfg_t cfg_reg;
    ipc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                ipc_pkg::REG_MOISTURE_LOW:  cfg_next.moisture_low  = wr_data[ipc_pkg::MOIST_W-1:0];
                ipc_pkg::REG_MOISTURE_HIGH: cfg_next.moisture_high = wr_data[ipc_pkg::MOIST_W-1:0];
                ipc_pkg::REG_MIN_GAP_MS:    cfg_next.min_gap_ms    = wr_data[ipc_pkg::TIME_W-1:0];
                ipc_pkg::REG_MAX_RUN_MS:    cfg_next.max_run_ms    = wr_data[ipc_pkg::TIME_W-1:0];
                ipc_pkg::REG_MANUAL_RUN_MS: cfg_next.manual_run_ms = wr_data[ipc_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.moisture_low  <= ipc_pkg::MOISTURE_LOW_RST;
            cfg_reg.moisture_high <= ipc_pkg::MOISTURE_HIGH_RST;
            cfg_reg.min_gap_ms    <= ipc_pkg::MIN_GAP_MS_RST;
            cfg_reg.max_run_ms    <= ipc_pkg::MAX_RUN_MS_RST;
            cfg_reg.manual_run_ms <= ipc_pkg::MANUAL_RUN_MS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/ipc_core.sv =====
// Controller state and the per-item update of mode, pump, LED and run timers.
module ipc_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  ipc_pkg::cfg_t     cfg,
    input  ipc_pkg::item_t    item,
    input  logic              fire,
    output ipc_pkg::result_t  result
);

    logic                          mode_reg, mode_next;
    logic                          pump_reg, pump_next;
    logic [ipc_pkg::LED_W-1:0]     led_reg, led_next;
    logic [ipc_pkg::TIME_W-1:0]    run_start_reg, run_start_next;
    logic [ipc_pkg::TIME_W-1:0]    last_end_reg, last_end_next;

    logic                          low;
    logic [ipc_pkg::TIME_W-1:0]    since_end;
    logic [ipc_pkg::TIME_W-1:0]    since_start;

    always_comb begin
        mode_next      = mode_reg;
        pump_next      = pump_reg;
        led_next       = led_reg;
        run_start_next = run_start_reg;
        last_end_next  = last_end_reg;
        low            = item.moisture < cfg.moisture_low;
        since_end      = item.now_ms - last_end_reg;

        if (item.mode_press) begin
            if (!mode_reg) begin
                mode_next = 1'b1;
                if (pump_reg) begin
                    pump_next = 1'b0;
                    if (led_reg == ipc_pkg::LED_PUMPING) begin
                        led_next = ipc_pkg::LED_IDLE;
                    end
                end
            end else begin
                mode_next = 1'b0;
            end
        end

        if (item.pump_press && mode_next) begin
            pump_next      = 1'b1;
            run_start_next = item.now_ms;
            led_next       = ipc_pkg::LED_PUMPING;
        end

        if (!mode_next) begin
            if (!pump_next && low && (since_end > cfg.min_gap_ms)) begin
                pump_next      = 1'b1;
                led_next       = ipc_pkg::LED_PUMPING;
                run_start_next = item.now_ms;
            end
        end

        since_start = item.now_ms - run_start_next;

        if (!mode_next) begin
            if (pump_next && ((item.moisture >= cfg.moisture_high) ||
                              (since_start >= cfg.max_run_ms))) begin
                pump_next     = 1'b0;
                last_end_next = item.now_ms;
                led_next      = ipc_pkg::LED_IDLE;
            end
            if (low && !pump_next) begin
                led_next = ipc_pkg::LED_ALERT;
            end
        end else begin
            if (pump_next && (since_start >= cfg.manual_run_ms)) begin
                pump_next = 1'b0;
                led_next  = low ? ipc_pkg::LED_ALERT : ipc_pkg::LED_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b0;
            pump_reg      <= 1'b0;
            led_reg       <= ipc_pkg::LED_IDLE;
            run_start_reg <= '0;
            last_end_reg  <= '0;
        end else if (fire) begin
            mode_reg      <= mode_next;
            pump_reg      <= pump_next;
            led_reg       <= led_next;
            run_start_reg <= run_start_next;
            last_end_reg  <= last_end_next;
        end
    end

    assign result.manual_mode = mode_next;
    assign result.pump_on     = pump_next;
    assign result.led_state   = led_next;

endmodule

// ===== rtl/ipc_checker.sv =====
// Port-level checker for the irrigation pump controller and its bind.
module ipc_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [ipc_pkg::M_TDATA_W-1:0]       m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_pump_led: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[3:2] == ipc_pkg::LED_PUMPING)
        else $error("pump on without watering LED");

    a_led_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:2] != ipc_pkg::LED_PUMPING |-> !m_tdata[1])
        else $error("pump on while LED not watering");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output valid or input blocked after reset");

endmodule

bind irrigation_pump_controller_top ipc_checker u_ipc_checker (.*);
